// ===== hw/rtl/bspta_pkg.sv =====
// ----------------------------------------------------------------------------
// bspta_pkg
// Shared types and constants of the space partition tree archive.
// ----------------------------------------------------------------------------
package bspta_pkg;

  localparam int COORD_W = 32;
  localparam int FIT_W   = 64;
  localparam int AXIS_W  = 6;
  localparam int CHILD_W = 16;

  localparam logic CMD_SEARCH = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic CFG_LOWER = 1'b0;
  localparam logic CFG_UPPER = 1'b1;

  localparam logic [1:0] STAT_SEARCH  = 2'd0;
  localparam logic [1:0] STAT_INSERT  = 2'd1;
  localparam logic [1:0] STAT_REFUSED = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        leaf;
    logic [FIT_W-1:0]  fit;
  } op_t;

  typedef struct packed {
    logic                is_inner;
    logic [AXIS_W-1:0]   axis;
    logic [COORD_W-1:0]  smin;
    logic [COORD_W-1:0]  smax;
    logic [CHILD_W-1:0]  lchild;
    logic [CHILD_W-1:0]  rchild;
    logic [FIT_W-1:0]    fitness;
  } node_t;

  typedef struct packed {
    logic [7:0]          leaf;
    logic                empty;
    logic [5:0]          dim;
    logic [COORD_W-1:0]  lo;
    logic [COORD_W-1:0]  hi;
    logic [COORD_W-1:0]  coord;
    logic [FIT_W-1:0]    fit;
    logic [1:0]          status;
    logic                last;
  } res_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DISPATCH,
    BK_SRD,
    BK_SEVAL,
    BK_ORD,
    BK_OEMIT,
    BK_ROOT,
    BK_IRD,
    BK_ICHK,
    BK_MRD,
    BK_MCMP,
    BK_SPLIT,
    BK_WPT,
    BK_WREC
  } back_state_e;

endpackage

// ===== hw/rtl/bspta_fifo.sv =====
// ----------------------------------------------------------------------------
// bspta_fifo
// Two-entry operation queue between the front and the back.
// ----------------------------------------------------------------------------
module bspta_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] ent_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= data_i;
  end

endmodule

// ===== hw/rtl/bspta_front.sv =====
// ----------------------------------------------------------------------------
// bspta_front
// Collects coordinates into the point buffer and queues complete operations.
// ----------------------------------------------------------------------------
module bspta_front import bspta_pkg::*; #(
  parameter int DIMENSIONS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             full_i,
  input  logic                             command_i,
  input  logic [7:0]                       leaf_index_i,
  input  logic signed [31:0]               coordinate_i,
  input  logic signed [63:0]               fitness_i,
  input  logic                             last_coordinate_i,
  output logic                             push_o,
  output op_t                              op_o,
  output logic [DIMENSIONS*COORD_W-1:0]    point_o
);

  localparam int CW = $clog2(DIMENSIONS + 1);
  localparam int IW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

  logic [COORD_W-1:0] pbuf_q [DIMENSIONS];
  logic [CW-1:0]      cnt_q;
  logic               acc, room;

  assign acc  = start_i && !full_i;
  assign room = (cnt_q < CW'(DIMENSIONS));

  assign push_o   = acc && last_coordinate_i;
  assign op_o.cmd  = command_i;
  assign op_o.leaf = leaf_index_i;
  assign op_o.fit  = fitness_i;

  // The point sent on includes the coordinate arriving with the last item, if the buffer still has room.
  always_comb begin
    for (int d = 0; d < DIMENSIONS; d++) begin
      if (acc && room && (cnt_q == CW'(d))) begin
        point_o[d*COORD_W +: COORD_W] = coordinate_i;
      end else begin
        point_o[d*COORD_W +: COORD_W] = pbuf_q[d];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (acc) begin
      if (last_coordinate_i) cnt_q <= '0;
      else if (room) cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && room) pbuf_q[cnt_q[IW-1:0]] <= coordinate_i;
  end

endmodule

// ===== hw/rtl/bspta_back.sv =====
// ----------------------------------------------------------------------------
// bspta_back
// Executes queued searches and inserts against the node and point memories.
// ----------------------------------------------------------------------------
module bspta_back import bspta_pkg::*; #(
  parameter int DIMENSIONS = 8,
  parameter int MAX_NODES  = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  op_t                            op_i,
  input  logic [DIMENSIONS*COORD_W-1:0]  point_i,
  output logic                           pop_o,
  input  logic [COORD_W-1:0]             lower_i,
  input  logic [COORD_W-1:0]             upper_i,
  output logic                           res_valid_o,
  output res_t                           res_o
);

  localparam int CW  = $clog2(DIMENSIONS + 1);
  localparam int IW  = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = NW + 1;
  localparam int PAW = $clog2(MAX_NODES * DIMENSIONS);

  function automatic logic [PAW-1:0] paddr(logic [NW-1:0] node, logic [IW-1:0] j);
    paddr = PAW'(node) * PAW'(DIMENSIONS) + PAW'(j);
  endfunction

  function automatic res_t status_res(logic [1:0] s);
    res_t r;
    r        = '0;
    r.status = s;
    r.last   = 1'b1;
    status_res = r;
  endfunction

  // Memories.
  node_t              node_mem [MAX_NODES];
  logic [COORD_W-1:0] pt_mem   [MAX_NODES*DIMENSIONS];
  node_t              nm_rd_q;
  logic [COORD_W-1:0] pm_rd_q;
  logic               nm_re, nm_we, pm_re, pm_we;
  logic [NW-1:0]      nm_wa;
  node_t              nm_wd;
  logic [PAW-1:0]     pm_ra, pm_wa;
  logic [COORD_W-1:0] pm_wd;

  back_state_e        state_q, state_d;
  logic [NCW-1:0]     ncount_q, ncount_d;
  logic               rempty_q, rempty_d;
  logic               ov_q, ov_d;
  res_t               res_q, res_d;

  logic [COORD_W-1:0] pt_q [DIMENSIONS];
  logic [COORD_W-1:0] memo_q [DIMENSIONS], memo_d [DIMENSIONS];
  logic [COORD_W-1:0] rlo_q [DIMENSIONS], rlo_d [DIMENSIONS];
  logic [COORD_W-1:0] rhi_q [DIMENSIONS], rhi_d [DIMENSIONS];
  op_t                op_q;
  logic [NW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      j_q, j_d;
  logic [32:0]        best_q, best_d;
  logic [IW-1:0]      bd_q, bd_d;
  logic               left_q, left_d;
  logic               half_q, half_d;

  logic [IW-1:0]      sel;
  logic [COORD_W-1:0] pt_rd, memo_rd;
  logic [IW-1:0]      ax;
  logic               j_last, below;
  logic signed [32:0] twice, msum, diff;
  logic [32:0]        mag;
  logic [COORD_W-1:0] smin, smax;
  logic [NW-1:0]      lnode, rnode;

  assign pt_rd   = pt_q[sel];
  assign memo_rd = memo_q[sel];
  assign j_last  = (j_q == CW'(DIMENSIONS - 1));
  assign ax      = IW'(nm_rd_q.axis);
  assign lnode   = NW'(ncount_q + NCW'(1));
  assign rnode   = NW'(ncount_q + NCW'(2));
  assign pop_o   = (state_q == BK_IDLE) && !empty_i;
  assign pm_ra   = paddr(idx_q, j_q[IW-1:0]);

  assign res_valid_o = ov_q;
  assign res_o       = res_q;

  always_comb begin
    state_d  = state_q;
    ncount_d = ncount_q;
    rempty_d = rempty_q;
    ov_d     = 1'b0;
    res_d    = res_q;
    memo_d   = memo_q;
    rlo_d    = rlo_q;
    rhi_d    = rhi_q;
    idx_d    = idx_q;
    j_d      = j_q;
    best_d   = best_q;
    bd_d     = bd_q;
    left_d   = left_q;
    half_d   = half_q;
    nm_re    = 1'b0;
    nm_we    = 1'b0;
    nm_wa    = idx_q;
    nm_wd    = nm_rd_q;
    pm_re    = 1'b0;
    pm_we    = 1'b0;
    pm_wa    = paddr(idx_q, j_q[IW-1:0]);
    pm_wd    = pt_rd;
    sel      = j_q[IW-1:0];
    twice    = '0;
    msum     = '0;
    diff     = '0;
    mag      = '0;
    smin     = '0;
    smax     = '0;
    below    = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (!empty_i) state_d = BK_DISPATCH;
      end
      BK_DISPATCH: begin
        j_d    = '0;
        idx_d  = '0;
        half_d = 1'b0;
        if (op_q.cmd == CMD_SEARCH) begin
          if (rempty_q) begin
            ov_d       = 1'b1;
            res_d      = '0;
            res_d.empty = 1'b1;
            res_d.status = STAT_SEARCH;
            res_d.last = 1'b1;
            state_d    = BK_IDLE;
          end else begin
            for (int k = 0; k < DIMENSIONS; k++) begin
              rlo_d[k] = lower_i;
              rhi_d[k] = upper_i;
            end
            state_d = BK_SRD;
          end
        end else if (rempty_q) begin
          state_d = BK_ROOT;
        end else if ((18'(ncount_q) + 18'd2 >= 18'(MAX_NODES)) ||
                     (17'(op_q.leaf) > 17'(ncount_q))) begin
          ov_d    = 1'b1;
          res_d   = status_res(STAT_REFUSED);
          state_d = BK_IDLE;
        end else begin
          idx_d   = NW'(op_q.leaf);
          state_d = BK_IRD;
        end
      end
      BK_SRD: begin
        nm_re   = 1'b1;
        state_d = BK_SEVAL;
      end
      BK_SEVAL: begin
        if (!nm_rd_q.is_inner) begin
          j_d     = '0;
          state_d = BK_ORD;
        end else begin
          sel   = ax;
          twice = $signed({pt_rd, 1'b0});
          msum  = $signed({nm_rd_q.smin[31], nm_rd_q.smin}) +
                  $signed({nm_rd_q.smax[31], nm_rd_q.smax});
          if (twice < msum) begin
            rhi_d[ax] = nm_rd_q.smax;
            idx_d     = NW'(nm_rd_q.lchild);
          end else begin
            rlo_d[ax] = nm_rd_q.smin;
            idx_d     = NW'(nm_rd_q.rchild);
          end
          state_d = BK_SRD;
        end
      end
      BK_ORD: begin
        pm_re   = 1'b1;
        state_d = BK_OEMIT;
      end
      BK_OEMIT: begin
        ov_d         = 1'b1;
        res_d.leaf   = 8'(idx_q);
        res_d.empty  = 1'b0;
        res_d.dim    = 6'(j_q);
        res_d.lo     = rlo_q[0];
        res_d.hi     = rhi_q[0];
        res_d.coord  = pm_rd_q;
        res_d.fit    = nm_rd_q.fitness;
        res_d.status = STAT_SEARCH;
        res_d.last   = j_last;
        // The region rotates so that dimension j always sits in entry 0.
        for (int k = 0; k < DIMENSIONS - 1; k++) begin
          rlo_d[k] = rlo_q[k+1];
          rhi_d[k] = rhi_q[k+1];
        end
        rlo_d[DIMENSIONS-1] = rlo_q[0];
        rhi_d[DIMENSIONS-1] = rhi_q[0];
        j_d = j_q + CW'(1);
        state_d = j_last ? BK_IDLE : BK_ORD;
      end
      BK_ROOT: begin
        pm_we = 1'b1;
        pm_wa = paddr('0, j_q[IW-1:0]);
        pm_wd = pt_rd;
        j_d   = j_q + CW'(1);
        if (j_last) begin
          nm_we    = 1'b1;
          nm_wa    = '0;
          nm_wd    = '0;
          nm_wd.fitness = op_q.fit;
          rempty_d = 1'b0;
          ov_d     = 1'b1;
          res_d    = status_res(STAT_INSERT);
          state_d  = BK_IDLE;
        end
      end
      BK_IRD: begin
        nm_re   = 1'b1;
        state_d = BK_ICHK;
      end
      BK_ICHK: begin
        if (nm_rd_q.is_inner) begin
          ov_d    = 1'b1;
          res_d   = status_res(STAT_REFUSED);
          state_d = BK_IDLE;
        end else begin
          j_d     = '0;
          best_d  = '0;
          bd_d    = '0;
          state_d = BK_MRD;
        end
      end
      BK_MRD: begin
        pm_re   = 1'b1;
        state_d = BK_MCMP;
      end
      BK_MCMP: begin
        memo_d[j_q[IW-1:0]] = pm_rd_q;
        diff = $signed({pm_rd_q[31], pm_rd_q}) - $signed({pt_rd[31], pt_rd});
        mag  = diff[32] ? 33'(-diff) : 33'(diff);
        if (best_q < mag) begin
          best_d = mag;
          bd_d   = j_q[IW-1:0];
        end
        j_d     = j_q + CW'(1);
        state_d = j_last ? BK_SPLIT : BK_MRD;
      end
      BK_SPLIT: begin
        sel = bd_q;
        if ($signed(memo_rd) < $signed(pt_rd)) begin
          smin = memo_rd;
          smax = pt_rd;
        end else begin
          smin = pt_rd;
          smax = memo_rd;
        end
        twice = $signed({pt_rd, 1'b0});
        msum  = $signed({smin[31], smin}) + $signed({smax[31], smax});
        below = (twice < msum);
        nm_we        = 1'b1;
        nm_wa        = idx_q;
        nm_wd.is_inner = 1'b1;
        nm_wd.axis   = AXIS_W'(bd_q);
        nm_wd.smin   = smin;
        nm_wd.smax   = smax;
        nm_wd.lchild = CHILD_W'(lnode);
        nm_wd.rchild = CHILD_W'(rnode);
        left_d  = below;
        j_d     = '0;
        half_d  = 1'b0;
        state_d = BK_WPT;
      end
      BK_WPT: begin
        pm_we = 1'b1;
        pm_wa = paddr(half_q ? rnode : lnode, j_q[IW-1:0]);
        pm_wd = (left_q ^ half_q) ? pt_rd : memo_rd;
        half_d = ~half_q;
        if (half_q) begin
          j_d = j_q + CW'(1);
          if (j_last) state_d = BK_WREC;
        end
      end
      BK_WREC: begin
        nm_we  = 1'b1;
        nm_wa  = half_q ? rnode : lnode;
        nm_wd  = '0;
        nm_wd.fitness = (left_q ^ half_q) ? op_q.fit : nm_rd_q.fitness;
        half_d = ~half_q;
        if (half_q) begin
          ncount_d = ncount_q + NCW'(2);
          ov_d     = 1'b1;
          res_d    = status_res(STAT_INSERT);
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      ncount_q <= '0;
      rempty_q <= 1'b1;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ncount_q <= ncount_d;
      rempty_q <= rempty_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    memo_q <= memo_d;
    rlo_q  <= rlo_d;
    rhi_q  <= rhi_d;
    idx_q  <= idx_d;
    j_q    <= j_d;
    best_q <= best_d;
    bd_q   <= bd_d;
    left_q <= left_d;
    half_q <= half_d;
    if (pop_o) begin
      op_q <= op_i;
      for (int k = 0; k < DIMENSIONS; k++) pt_q[k] <= point_i[k*COORD_W +: COORD_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nm_we) node_mem[nm_wa] <= nm_wd;
    if (nm_re) nm_rd_q <= node_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) pt_mem[pm_wa] <= pm_wd;
    if (pm_re) pm_rd_q <= pt_mem[pm_ra];
  end

endmodule

// ===== hw/rtl/bsp_tree_point_archive_top.sv =====
// ----------------------------------------------------------------------------
// bsp_tree_point_archive_top
// Binary space partition archive of points with fitness values.
// ----------------------------------------------------------------------------
// Usage: a point arrives one coordinate per item on the command channel. An
// item is accepted on a rising edge with start_i high and busy_o low. The item
// marked last_coordinate_i queues the operation (search or insert) together
// with the buffered point; busy_o rises only while the two-entry operation
// queue is full.
// Results come out one per strobe on result_valid_o, each valid for exactly
// one cycle; the receiver cannot stall them. A search gives one result per
// dimension; an insert or an empty-tree search gives one.
// A search is paced by the single read port of the node memory during the
// descent and of the point memory during readout. An insert reads the old
// leaf point, then writes both child points through the one point memory
// write port.
// Configuration writes (lower and upper bound) are always ready and must be
// made only while the block is idle.
// Reset empties the tree and the queue; no clearing pass is needed since
// every node is written when it is allocated.
// ----------------------------------------------------------------------------
module bsp_tree_point_archive_top import bspta_pkg::*; #(
  parameter int DIMENSIONS = 8,
  parameter int MAX_NODES  = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               command_i,
  input  logic [7:0]         leaf_index_i,
  input  logic signed [31:0] coordinate_i,
  input  logic signed [63:0] fitness_i,
  input  logic               last_coordinate_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [7:0]         found_leaf_o,
  output logic               tree_empty_o,
  output logic [5:0]         dimension_index_o,
  output logic signed [31:0] box_low_o,
  output logic signed [31:0] box_high_o,
  output logic signed [31:0] leaf_coordinate_o,
  output logic signed [63:0] leaf_fitness_o,
  output logic [1:0]         status_o,
  output logic               last_result_o
);

  localparam int QW = $bits(op_t) + DIMENSIONS * COORD_W;

  logic                          push, pop, full, empty;
  op_t                           f_op, b_op;
  logic [DIMENSIONS*COORD_W-1:0] f_pt, b_pt;
  logic [QW-1:0]                 q_out;
  logic [COORD_W-1:0]            lower_q, upper_q;
  res_t                          res;

  assign busy_o      = full;
  assign cfg_ready_o = 1'b1;

  // The bounds seed the search region in every dimension.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= 32'sd0;
      upper_q <= 32'sd65536;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_LOWER) lower_q <= cfg_data_i;
      else if (cfg_index_i == CFG_UPPER) upper_q <= cfg_data_i;
    end
  end

  bspta_front #(.DIMENSIONS(DIMENSIONS)) u_front (
    .clk_i, .rst_ni, .start_i, .full_i(full), .command_i, .leaf_index_i,
    .coordinate_i, .fitness_i, .last_coordinate_i,
    .push_o(push), .op_o(f_op), .point_o(f_pt)
  );

  bspta_fifo #(.W(QW)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i({f_op, f_pt}), .pop_i(pop),
    .data_o(q_out), .full_o(full), .empty_o(empty)
  );

  assign {b_op, b_pt} = q_out;

  bspta_back #(.DIMENSIONS(DIMENSIONS), .MAX_NODES(MAX_NODES)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .op_i(b_op), .point_i(b_pt), .pop_o(pop),
    .lower_i(lower_q), .upper_i(upper_q), .res_valid_o(result_valid_o), .res_o(res)
  );

  assign found_leaf_o      = res.leaf;
  assign tree_empty_o      = res.empty;
  assign dimension_index_o = res.dim;
  assign box_low_o         = res.lo;
  assign box_high_o        = res.hi;
  assign leaf_coordinate_o = res.coord;
  assign leaf_fitness_o    = res.fit;
  assign status_o          = res.status;
  assign last_result_o     = res.last;

endmodule

// ===== hw/rtl/bspta_checker.sv =====
// ----------------------------------------------------------------------------
// bspta_checker
// Port level checks on the result stream of the archive.
// ----------------------------------------------------------------------------
module bspta_checker import bspta_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       result_valid_o,
  input logic       tree_empty_o,
  input logic [5:0] dimension_index_o,
  input logic [1:0] status_o,
  input logic       last_result_o
);

  // Insert results are single and final.
  a_insert_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != STAT_SEARCH) |-> last_result_o)
    else $error("insert result not marked last");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o <= STAT_REFUSED))
    else $error("undefined status code");

  a_empty_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && tree_empty_o) |-> (last_result_o && dimension_index_o == 6'd0))
    else $error("empty tree result malformed");

  // A non-final search result is followed by the next dimension's result, with no strobe in between.
  a_search_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == STAT_SEARCH && !tree_empty_o && !last_result_o)
    |=> (!result_valid_o ##1 (result_valid_o &&
         dimension_index_o == $past(dimension_index_o, 2) + 6'd1)))
    else $error("search result sequence broken");

endmodule

bind bsp_tree_point_archive_top bspta_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .result_valid_o(result_valid_o),
  .tree_empty_o(tree_empty_o), .dimension_index_o(dimension_index_o),
  .status_o(status_o), .last_result_o(last_result_o)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the space partition tree archive: drives points one
// coordinate per item, predicts every search and insert result in a local
// model of the tree and checks each strobed result field by field.
// ----------------------------------------------------------------------------
module tb;
  import bspta_pkg::*;

  localparam int DIMS  = 8;
  localparam int NODES = 256;
  // Longest descent plus readout, with margin; used before register writes
  // and at the end of the run.
  localparam int SETTLE_CYCLES = 400;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               command_i;
  logic [7:0]         leaf_index_i;
  logic signed [31:0] coordinate_i;
  logic signed [63:0] fitness_i;
  logic               last_coordinate_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               result_valid_o;
  logic [7:0]         found_leaf_o;
  logic               tree_empty_o;
  logic [5:0]         dimension_index_o;
  logic signed [31:0] box_low_o;
  logic signed [31:0] box_high_o;
  logic signed [31:0] leaf_coordinate_o;
  logic signed [63:0] leaf_fitness_o;
  logic [1:0]         status_o;
  logic               last_result_o;

  bsp_tree_point_archive_top #(
    .DIMENSIONS(DIMS),
    .MAX_NODES (NODES)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .command_i        (command_i),
    .leaf_index_i     (leaf_index_i),
    .coordinate_i     (coordinate_i),
    .fitness_i        (fitness_i),
    .last_coordinate_i(last_coordinate_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_valid_o   (result_valid_o),
    .found_leaf_o     (found_leaf_o),
    .tree_empty_o     (tree_empty_o),
    .dimension_index_o(dimension_index_o),
    .box_low_o        (box_low_o),
    .box_high_o       (box_high_o),
    .leaf_coordinate_o(leaf_coordinate_o),
    .leaf_fitness_o   (leaf_fitness_o),
    .status_o         (status_o),
    .last_result_o    (last_result_o)
  );

  always #10 clk_i = ~clk_i;

  // Local copy of the tree. Coordinates are kept as longint so that the
  // midpoint test 2*c < min+max is exact without any overflow.
  longint      lower_bnd, upper_bnd;
  longint      point_buf [DIMS];
  int          coord_cnt;
  longint      node_pts  [NODES][DIMS];
  logic [63:0] node_fit  [NODES];
  bit          node_inner[NODES];
  int          node_axis [NODES];
  longint      node_smin [NODES];
  longint      node_smax [NODES];
  int          node_left [NODES];
  int          node_right[NODES];
  int          node_cnt;
  bit          tree_is_empty;

  res_t        expected_results[$];
  int          error_cnt = 0;
  int          idle_pct;  // chance in percent of an idle burst after an item

  // Clears the model to its state after reset.
  task automatic reset_tree();
    lower_bnd = 0;
    upper_bnd = 65536;
    coord_cnt = 0;
    node_cnt = 0;
    tree_is_empty = 1'b1;
    for (int n = 0; n < NODES; n++) begin
      node_fit[n] = 64'h7FFF_FFFF_FFFF_FFFF;
      node_inner[n] = 1'b0;
    end
  endtask

  // Descends the tree with the buffered point and queues one result per
  // dimension, or a single empty-tree result.
  task automatic predict_search();
    res_t   r;
    longint reg_lo[DIMS];
    longint reg_hi[DIMS];
    int     idx, steps, d, nxt;
    r = '0;
    if (tree_is_empty) begin
      r.empty = 1'b1;
      r.status = STAT_SEARCH;
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    for (int j = 0; j < DIMS; j++) begin
      reg_lo[j] = lower_bnd;
      reg_hi[j] = upper_bnd;
    end
    idx = 0;
    steps = 0;
    while (node_inner[idx] && steps < NODES) begin
      d = node_axis[idx];
      if (2 * point_buf[d] < node_smin[idx] + node_smax[idx]) begin
        reg_hi[d] = node_smax[idx];
        nxt = node_left[idx];
      end else begin
        reg_lo[d] = node_smin[idx];
        nxt = node_right[idx];
      end
      if (nxt >= NODES) break;
      idx = nxt;
      steps++;
    end
    for (int j = 0; j < DIMS; j++) begin
      r.leaf = idx[7:0];
      r.empty = 1'b0;
      r.dim = j[5:0];
      r.lo = reg_lo[j][31:0];
      r.hi = reg_hi[j][31:0];
      r.coord = node_pts[idx][j][31:0];
      r.fit = node_fit[idx];
      r.status = STAT_SEARCH;
      r.last = (j == DIMS - 1);
      expected_results.push_back(r);
    end
  endtask

  // Splits a leaf on the axis of the largest coordinate difference, or fills
  // the root of an empty tree, or refuses when the store or leaf rules fail.
  task automatic predict_insert(int leaf, logic [63:0] fit);
    res_t        r;
    longint      old_pt[DIMS];
    logic [63:0] old_fit;
    longint      best, diff;
    int          d, lc, rc;
    r = '0;
    r.last = 1'b1;
    r.status = STAT_INSERT;
    if (tree_is_empty) begin
      tree_is_empty = 1'b0;
      node_inner[0] = 1'b0;
      node_pts[0] = point_buf;
      node_fit[0] = fit;
    end else if (node_cnt + 2 >= NODES || leaf > node_cnt || node_inner[leaf]) begin
      r.status = STAT_REFUSED;
    end else begin
      old_pt = node_pts[leaf];
      old_fit = node_fit[leaf];
      best = 0;
      d = 0;
      for (int i = 0; i < DIMS; i++) begin
        diff = old_pt[i] - point_buf[i];
        if (diff < 0) diff = -diff;
        if (best < diff) begin
          best = diff;
          d = i;
        end
      end
      node_inner[leaf] = 1'b1;
      node_axis[leaf] = d;
      node_smin[leaf] = (old_pt[d] < point_buf[d]) ? old_pt[d] : point_buf[d];
      node_smax[leaf] = (old_pt[d] < point_buf[d]) ? point_buf[d] : old_pt[d];
      lc = node_cnt + 1;
      rc = node_cnt + 2;
      node_cnt += 2;
      node_left[leaf] = lc;
      node_right[leaf] = rc;
      node_inner[lc] = 1'b0;
      node_inner[rc] = 1'b0;
      if (2 * point_buf[d] < node_smin[leaf] + node_smax[leaf]) begin
        node_pts[lc] = point_buf;
        node_fit[lc] = fit;
        node_pts[rc] = old_pt;
        node_fit[rc] = old_fit;
      end else begin
        node_pts[lc] = old_pt;
        node_fit[lc] = old_fit;
        node_pts[rc] = point_buf;
        node_fit[rc] = fit;
      end
    end
    expected_results.push_back(r);
  endtask

  // Applies one accepted item to the model.
  task automatic predict_item(logic cmd, logic [7:0] leaf, logic [31:0] coord,
                              logic [63:0] fit, logic last);
    if (coord_cnt < DIMS) begin
      point_buf[coord_cnt] = longint'(signed'(coord));
      coord_cnt++;
    end
    if (last) begin
      coord_cnt = 0;
      if (cmd == CMD_SEARCH) predict_search();
      else predict_insert(int'(leaf), fit);
    end
  endtask

  // Sends one item and returns at the edge that accepted it. Start stays high
  // unless an idle burst follows, so back-to-back items keep it asserted.
  task automatic send_item(logic cmd, logic [7:0] leaf, logic [31:0] coord,
                           logic [63:0] fit, logic last);
    start_i <= 1'b1;
    command_i <= cmd;
    leaf_index_i <= leaf;
    coordinate_i <= coord;
    fitness_i <= fit;
    last_coordinate_i <= last;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    predict_item(cmd, leaf, coord, fit, last);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Random 32-bit values half of the time, with extremes and small values mixed in so
  // that splits and midpoints land both near zero and at the rails.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: rand_coord = 32'h8000_0000;
      1: rand_coord = 32'h7FFF_FFFF;
      2: rand_coord = $urandom_range(0, 131072);
      default: rand_coord = $urandom;
    endcase
  endfunction

  // Sends n_coord random coordinates as one point; the last item starts the
  // operation.
  task automatic send_point(logic cmd, logic [7:0] leaf, int n_coord);
    logic [63:0] fit;
    fit = {$urandom, $urandom};
    for (int i = 0; i < n_coord; i++)
      send_item(cmd, leaf, rand_coord(), fit, i == n_coord - 1);
  endtask

  // Sends a point with the same value in every dimension.
  task automatic send_flat_point(logic cmd, logic [7:0] leaf, logic [31:0] value,
                                 logic [63:0] fit);
    for (int i = 0; i < DIMS; i++)
      send_item(cmd, leaf, value, fit, i == DIMS - 1);
  endtask

  // Picks an allocated leaf of the model at random.
  function automatic logic [7:0] pick_leaf();
    int n;
    n = $urandom_range(0, node_cnt);
    while (node_inner[n]) n = $urandom_range(0, node_cnt);
    return n[7:0];
  endfunction

  // Lets every expected result arrive and the block settle before the
  // registers change or the run ends.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bound(logic idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_LOWER) lower_bnd = longint'(signed'(value));
    else upper_bnd = longint'(signed'(value));
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_cnt++;
    end
  endtask

  // Every strobe is compared against the oldest expectation. Both sides are
  // zero extended so that signed fields compare bit for bit.
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual leaf %0d status %0d",
                 $time, found_leaf_o, status_o);
        error_cnt++;
      end else begin
        e = expected_results.pop_front();
        check_field("found_leaf", 64'(e.leaf), 64'(found_leaf_o));
        check_field("tree_empty", 64'(e.empty), 64'(tree_empty_o));
        check_field("dimension_index", 64'(e.dim), 64'(dimension_index_o));
        check_field("box_low", 64'(e.lo), 64'($unsigned(box_low_o)));
        check_field("box_high", 64'(e.hi), 64'($unsigned(box_high_o)));
        check_field("leaf_coordinate", 64'(e.coord), 64'($unsigned(leaf_coordinate_o)));
        check_field("leaf_fitness", e.fit, $unsigned(leaf_fitness_o));
        check_field("status", 64'(e.status), 64'(status_o));
        check_field("last_result", 64'(e.last), 64'(last_result_o));
      end
    end
  end

  // Empty tree: a search reports tree_empty, then an insert with an unused
  // leaf index fills the root and a search reads it back.
  task automatic test_empty_tree();
    idle_pct = 0;
    send_point(CMD_SEARCH, 8'd0, DIMS);
    send_point(CMD_INSERT, 8'd200, DIMS);
    send_point(CMD_SEARCH, 8'hFF, DIMS);
  endtask

  // Extremes, equal points, excess and short points and refused inserts.
  task automatic test_directed();
    idle_pct = 30;
    // An equal point splits on axis 0 (all differences are zero).
    for (int i = 0; i < DIMS; i++)
      send_item(CMD_INSERT, 8'd0, node_pts[0][i][31:0], 64'h8000_0000_0000_0000,
                i == DIMS - 1);
    send_flat_point(CMD_INSERT, 8'd1, 32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_flat_point(CMD_INSERT, 8'd2, 32'h7FFF_FFFF, 64'h0);
    send_flat_point(CMD_SEARCH, 8'd0, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // Two coordinates beyond the dimension count are dropped.
    send_point(CMD_SEARCH, 8'd0, DIMS + 2);
    // A short point keeps the rest of the previous one.
    send_point(CMD_INSERT, pick_leaf(), 2);
    // Refused: the root is internal now, and a leaf index past the store.
    send_point(CMD_INSERT, 8'd0, 1);
    send_point(CMD_INSERT, 8'd255, 1);
    send_point(CMD_SEARCH, 8'd0, 1);
  endtask

  // Random traffic of searches and inserts, mostly with short points, on real leaves
  // with some inserts on arbitrary leaf indexes.
  task automatic run_random(int n_ops);
    logic       cmd;
    logic [7:0] leaf;
    int         n_coord;
    for (int k = 0; k < n_ops; k++) begin
      cmd = 1'($urandom_range(0, 1));
      leaf = ($urandom_range(0, 4) == 0) ? 8'($urandom) : pick_leaf();
      case ($urandom_range(0, 3))
        0: n_coord = $urandom_range(1, DIMS + 3);
        default: n_coord = $urandom_range(1, 2);
      endcase
      send_point(cmd, leaf, n_coord);
    end
  endtask

  // Register settings, the extremes among them; a random phase under each.
  task automatic test_bounds();
    logic [31:0] lo_set[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000};
    logic [31:0] hi_set[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h1234_5678};
    for (int p = 0; p < 4; p++) begin
      drain();
      write_bound(CFG_LOWER, lo_set[p]);
      write_bound(CFG_UPPER, hi_set[p]);
      idle_pct = (p % 2) ? 0 : 40;
      run_random(12);
    end
  endtask

  // Fills the store with one-coordinate inserts, then checks the refusal.
  task automatic test_full_store();
    idle_pct = 20;
    while (node_cnt + 2 < NODES) send_point(CMD_INSERT, pick_leaf(), 1);
    send_point(CMD_INSERT, pick_leaf(), 1);
    send_point(CMD_INSERT, 8'd0, DIMS);
    send_point(CMD_SEARCH, 8'd0, DIMS);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i <= 1'b0;
    command_i <= CMD_SEARCH;
    leaf_index_i <= '0;
    coordinate_i <= '0;
    fitness_i <= '0;
    last_coordinate_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_LOWER;
    cfg_data_i <= '0;
    reset_tree();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_tree();
    test_directed();
    test_bounds();
    idle_pct = 35;
    run_random(10);
    test_full_store();
    // Closing stretch with no idling at all.
    idle_pct = 0;
    run_random(15);

    drain();
    if (error_cnt == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #(20 * 600000);
    $display("tb: FAIL");
    $finish;
  end

endmodule
